/* rtl/perlin_noise_2d_height_macros.svh */
// Assertion macros for the noise sampler RTL.
// Included by the top level, which carries concurrent assertions.
`ifndef PERLIN_NOISE_2D_HEIGHT_MACROS_SVH
`define PERLIN_NOISE_2D_HEIGHT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pn2h_pkg.sv */
// Package for the 2D gradient-noise height sampler.
// Holds payload types, register indexes and reset values, the permutation table and the gradient function.
`timescale 1ns / 1ps
package pn2h_pkg;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] z_coord;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] noise_value;
        logic signed [31:0] height;
    } t_out_item;

    localparam logic [7:0] REG_NOISE_SCALE  = 8'd0;
    localparam logic [7:0] REG_HEIGHT_SCALE = 8'd1;
    localparam logic [15:0] NOISE_SCALE_RST  = 16'd3277;
    localparam logic [15:0] HEIGHT_SCALE_RST = 16'd1280;

    // Fixed permutation table.
    function automatic logic [7:0] perm(input logic [7:0] idx);
        logic [7:0] t [256];
        t = '{
            8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
            8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
            8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
            8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
            8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
            8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
            8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
            8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
            8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
            8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
            8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
            8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
            8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
            8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
            8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
            8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
            8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
            8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
            8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
            8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
            8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
            8'd215,8'd61,8'd156,8'd180};
        return t[idx];
    endfunction

    // Gradient dot product for one corner; offsets are signed Q16 in 18 bits.
    function automatic logic signed [18:0] grad(input logic [1:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = h[1] ? 19'(y) : 19'(x);
        v = h[1] ? 19'(x) : 19'(y);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

/* rtl/perlin_noise_2d_height.sv */
// Top level of the 2D gradient-noise height sampler.
// Depends on pn2h_pkg, pn2h_coord, pn2h_blend and the assertion macros.
//
// Usage:
//   Input channel i_valid / o_stall carries one (x, z) pair per transaction
//   in signed Q16.16. Output channel o_valid / i_stall carries the noise in
//   Q2.14 and the height in Q16.16. Configuration writes go through
//   i_cfg_we / i_cfg_idx / i_cfg_data: index 0 is the noise scale, index 1
//   the height scale; other indexes are ignored.
//   Throughput is one item per cycle while the output is not stalled. The
//   pipeline is eleven register stages (five for scaling and the fade
//   curve, six for hashing, blending and height scaling) that all
//   advance together.
//   When the receiver stalls, the whole pipeline holds only if the last
//   stage is full; bubbles inside the pipe do not close up, and o_stall
//   mirrors that hold.
//   A synchronous active-low reset clears all valid bits and loads the
//   default scales.
`timescale 1ns / 1ps
module perlin_noise_2d_height #(
    parameter int LATTICE_SIZE = 256,
    parameter int FRAC_BITS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pn2h_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output pn2h_pkg::t_out_item  o_item,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import pn2h_pkg::*;
    `include "perlin_noise_2d_height_macros.svh"

    localparam int DEPTH = 11;
    localparam int CW    = $clog2(LATTICE_SIZE);

    // Configuration registers.
    logic [15:0] r_nscale, r_hscale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nscale <= NOISE_SCALE_RST;
            r_hscale <= HEIGHT_SCALE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NOISE_SCALE)  r_nscale <= i_cfg_data;
            if (i_cfg_idx == REG_HEIGHT_SCALE) r_hscale <= i_cfg_data;
        end
    end

    // Global advance: the pipe moves unless a finished result is held.
    logic adv;
    logic [DEPTH-1:0] r_vld;
    assign adv     = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    logic [CW-1:0] cx, cz;
    logic [15:0] fx, fz;
    logic [16:0] u, v;

    pn2h_coord #(.LATTICE_SIZE(LATTICE_SIZE), .FRAC_BITS(FRAC_BITS)) u_cx (
        .i_clk(i_clk), .i_adv(adv), .i_coord(i_item.x_coord), .i_scale(r_nscale),
        .o_cell(cx), .o_frac(fx), .o_fade(u));
    pn2h_coord #(.LATTICE_SIZE(LATTICE_SIZE), .FRAC_BITS(FRAC_BITS)) u_cz (
        .i_clk(i_clk), .i_adv(adv), .i_coord(i_item.z_coord), .i_scale(r_nscale),
        .o_cell(cz), .o_frac(fz), .o_fade(v));

    pn2h_blend #(.LATTICE_SIZE(LATTICE_SIZE)) u_blend (
        .i_clk(i_clk), .i_adv(adv), .i_cx(cx), .i_cz(cz), .i_fx(fx), .i_fz(fz),
        .i_u(u), .i_v(v), .i_hscale(r_hscale), .o_item(o_item));

    `PN_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall,
        "input stalled without a held result")
    `PN_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_item), "held result changed")
    `PN_ASSERT_NEXT(a_shift, i_clk, i_rst_n, !o_stall && i_valid,
        r_vld[0], "accepted transaction not tracked")
endmodule

/* rtl/pn2h_coord.sv */
// Coordinate front end: scale, split into cell and fraction, fade curve.
// Depends on pn2h_pkg. Five register stages, advancing on i_adv.
`timescale 1ns / 1ps
module pn2h_coord #(
    parameter int LATTICE_SIZE = 256,
    parameter int FRAC_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [31:0] i_coord,
    input  logic [15:0] i_scale,
    output logic [$clog2(LATTICE_SIZE)-1:0] o_cell,
    output logic [15:0] o_frac,
    output logic [16:0] o_fade
);
    import pn2h_pkg::*;

    localparam int CW = $clog2(LATTICE_SIZE);
    localparam int SH = 32 - FRAC_BITS;

    // Stage A: exact product (arithmetic shift of the signed product is a floor).
    logic signed [48:0] r_prod, n_prod;
    logic [CW-1:0] r_cell;
    logic [15:0] r_fa, r_fb, r_fc;
    logic [33:0] r_tt;
    logic [35:0] r_q;
    logic [16:0] r_t2;
    logic [19:0] r_q16;
    logic [CW-1:0] r_cb, r_cc;
    logic [16:0] r_fade;
    logic [33:0] r_t3p;

    logic signed [48:0] sh;
    logic [15:0] frac_w;
    logic [FRAC_BITS-1:0] fpart;

    assign n_prod = $signed(i_coord) * $signed({1'b0, i_scale});
    assign sh     = r_prod >>> SH;
    assign fpart  = sh[FRAC_BITS-1:0];

    always_comb begin
        if (FRAC_BITS >= 16) frac_w = 16'(fpart >> (FRAC_BITS - 16));
        else                 frac_w = 16'({fpart, 16'd0} >> FRAC_BITS);
    end

    logic [35:0] q_w;
    logic [33:0] f_w;
    // 6t^2 + 10*2^32 - 15t*2^16 stays positive and below 2^36.
    assign q_w  = 36'(64'd6 * 64'(r_tt[31:0]) + (64'd10 << 32)
                - ((64'd15 * 64'(r_fa)) << 16));
    assign f_w  = 34'((64'(r_t3p[33:16] + 18'(r_t3p[15])) * 64'(r_q16) + 64'd32768) >> 16);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            // Stage B: split and square.
            r_cell <= CW'(sh >>> FRAC_BITS);
            r_fa   <= frac_w;
            r_tt   <= 34'(frac_w) * 34'(frac_w);
            // Stage C: inner polynomial and t^2.
            r_fb   <= r_fa;
            r_cb   <= r_cell;
            r_q    <= q_w;
            r_t2   <= 17'((r_tt + 34'd32768) >> 16);
            // Stage D: round inner polynomial, t^3 product.
            r_fc   <= r_fb;
            r_cc   <= r_cb;
            r_q16  <= 20'((r_q + 36'd32768) >> 16);
            r_t3p  <= 34'(r_t2) * 34'(r_fb);
            r_fade <= (f_w > 34'd65536) ? 17'd65536 : 17'(f_w);
        end
    end

    // Stage E output (t3 rounded then multiplied by q16).
    logic [CW-1:0] r_ce;
    logic [15:0] r_fe;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ce <= r_cc;
            r_fe <= r_fc;
        end
    end

    assign o_cell = r_ce;
    assign o_frac = r_fe;
    assign o_fade = r_fade;
endmodule

/* rtl/pn2h_blend.sv */
// Corner hashing, gradients, bilinear blend and output scaling.
// Depends on pn2h_pkg. Register stages advance on i_adv.
`timescale 1ns / 1ps
module pn2h_blend #(
    parameter int LATTICE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [$clog2(LATTICE_SIZE)-1:0] i_cx,
    input  logic [$clog2(LATTICE_SIZE)-1:0] i_cz,
    input  logic [15:0] i_fx,
    input  logic [15:0] i_fz,
    input  logic [16:0] i_u,
    input  logic [16:0] i_v,
    input  logic [15:0] i_hscale,
    output pn2h_pkg::t_out_item o_item
);
    import pn2h_pkg::*;

    logic [7:0] cx8, cz8;
    assign cx8 = 8'(i_cx);
    assign cz8 = 8'(i_cz);

    // Stage 1: first hash level.
    logic [7:0] r_px0, r_px1, r_cz1;
    logic [15:0] r_fx1, r_fz1;
    logic [16:0] r_u1, r_v1;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_px0 <= perm(cx8);
            r_px1 <= perm(cx8 + 8'd1);
            r_cz1 <= cz8;
            r_fx1 <= i_fx; r_fz1 <= i_fz; r_u1 <= i_u; r_v1 <= i_v;
        end
    end

    // Stage 2: corner hashes and gradients.
    logic signed [17:0] ax, bx, az, bz;
    assign ax = $signed({2'b00, r_fx1});
    assign bx = ax - 18'sd65536;
    assign az = $signed({2'b00, r_fz1});
    assign bz = az - 18'sd65536;
    logic [7:0] h_aa, h_ba, h_ab, h_bb;
    assign h_aa = perm(r_px0 + r_cz1);
    assign h_ba = perm(r_px1 + r_cz1);
    assign h_ab = perm(r_px0 + r_cz1 + 8'd1);
    assign h_bb = perm(r_px1 + r_cz1 + 8'd1);
    logic signed [18:0] r_gaa, r_gba, r_gab, r_gbb;
    logic [16:0] r_u2, r_v2;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gaa <= grad(h_aa[1:0], ax, az);
            r_gba <= grad(h_ba[1:0], bx, az);
            r_gab <= grad(h_ab[1:0], ax, bz);
            r_gbb <= grad(h_bb[1:0], bx, bz);
            r_u2 <= r_u1; r_v2 <= r_v1;
        end
    end

    // Stage 3: x lerps.
    logic signed [37:0] px0, px1;
    assign px0 = (38'(r_gba) - 38'(r_gaa)) * $signed({1'b0, r_u2});
    assign px1 = (38'(r_gbb) - 38'(r_gab)) * $signed({1'b0, r_u2});
    logic signed [19:0] r_x0, r_x1;
    logic [16:0] r_v3;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x0 <= 20'(r_gaa) + 20'((px0 + 38'sd32768) >>> 16);
            r_x1 <= 20'(r_gab) + 20'((px1 + 38'sd32768) >>> 16);
            r_v3 <= r_v2;
        end
    end

    // Stage 4: z lerp, round to Q2.14, saturate.
    logic signed [39:0] pz;
    logic signed [20:0] n16;
    logic signed [18:0] n14w;
    assign pz   = 40'(21'(r_x1) - 21'(r_x0)) * $signed({1'b0, r_v3});
    assign n16  = 21'(r_x0) + 21'((pz + 40'sd32768) >>> 16);
    assign n14w = 19'((n16 + 21'sd2) >>> 2);
    logic signed [15:0] r_n14;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (n14w > 19'sd32767)       r_n14 <= 16'sh7fff;
            else if (n14w < -19'sd32768) r_n14 <= 16'sh8000;
            else                         r_n14 <= 16'(n14w);
        end
    end

    // Stage 5: height product; stage 6: round and saturate.
    logic signed [32:0] r_hp;
    logic signed [15:0] r_n5;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hp <= r_n14 * $signed({1'b0, i_hscale});
            r_n5 <= r_n14;
        end
    end

    logic signed [32:0] hw;
    assign hw = (r_hp + 33'sd32) >>> 6;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_item.noise_value <= r_n5;
            if (hw > 33'sd2147483647)       o_item.height <= 32'h7fffffff;
            else if (hw < -33'sd2147483648) o_item.height <= 32'h80000000;
            else                            o_item.height <= 32'(hw);
        end
    end
endmodule
